// ===== rtl/atu_pkg.sv =====
package atu_pkg;

  localparam int TABLE_LEN = 24;
  localparam int STEP_W    = $clog2(TABLE_LEN);
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int IN_SHIFT  = 14;
  // datapath lanes: |count| << 14 plus CORDIC growth stays well below 2^32
  localparam int DW        = 34;
  // angle accumulator, Q20 degrees, peaks near 100 degrees
  localparam int ZW        = 32;
  localparam int ANG_Q     = 20;
  // pass-one magnitude is nonnegative and below 2^31
  localparam int MAG_W     = 31;
  localparam int GAIN_W    = 30;
  localparam int GAIN_SH   = 30;
  localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = GAIN_W'(652032874);
  localparam int ANG_LIMIT_DEG = 90;

  typedef struct packed {
    logic signed [DW-1:0] a;     // x lane
    logic signed [DW-1:0] b;     // y lane
    logic signed [ZW-1:0] z;     // angle accumulator
    logic signed [DW-1:0] y_raw; // shifted Y count, carried through pass one
    logic                 zero;  // Y axis was zero: result forced to 0
  } cord_t;

  // round(atan(2^-i) * 180/pi * 2^20)
  function automatic logic signed [ZW-1:0] atan_q20(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0:  v = ZW'(47185920);
      1:  v = ZW'(27855475);
      2:  v = ZW'(14718068);
      3:  v = ZW'(7471121);
      4:  v = ZW'(3750058);
      5:  v = ZW'(1876857);
      6:  v = ZW'(938658);
      7:  v = ZW'(469357);
      8:  v = ZW'(234682);
      9:  v = ZW'(117342);
      10: v = ZW'(58671);
      11: v = ZW'(29335);
      12: v = ZW'(14668);
      13: v = ZW'(7334);
      14: v = ZW'(3667);
      15: v = ZW'(1833);
      16: v = ZW'(917);
      17: v = ZW'(458);
      18: v = ZW'(229);
      19: v = ZW'(115);
      20: v = ZW'(57);
      21: v = ZW'(29);
      22: v = ZW'(14);
      23: v = ZW'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/atu_cordic_cell.sv =====
module atu_cordic_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            angle_mode, // 0: magnitude pass, 1: angle pass
  input  logic [atu_pkg::STEP_W-1:0]      step,
  input  logic signed [atu_pkg::ZW-1:0]   atan_val,
  input  logic                            up_vld,
  output logic                            up_rdy,
  input  atu_pkg::cord_t                  up_data,
  output logic                            dn_vld,
  input  logic                            dn_rdy,
  output atu_pkg::cord_t                  dn_data
);

  logic                           vld_r;
  atu_pkg::cord_t                 data_r;
  atu_pkg::cord_t                 data_nxt;
  logic signed [atu_pkg::DW-1:0]  xs;
  logic signed [atu_pkg::DW-1:0]  ys;
  logic                           rot_pos;

  // a bubble in this cell lets the upstream cell move even when downstream is stuck
  assign up_rdy = !vld_r || dn_rdy;

  always_comb begin
    xs = up_data.a >>> step;
    ys = up_data.b >>> step;
    // magnitude pass rotates toward zero with b == 0 counted as positive
    rot_pos = angle_mode ? (up_data.b > 0) : (up_data.b >= 0);
    data_nxt = up_data;
    if (rot_pos) begin
      data_nxt.a = up_data.a + ys;
      data_nxt.b = up_data.b - xs;
      data_nxt.z = angle_mode ? up_data.z + atan_val : up_data.z;
    end else begin
      data_nxt.a = up_data.a - ys;
      data_nxt.b = up_data.b + xs;
      data_nxt.z = angle_mode ? up_data.z - atan_val : up_data.z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_data = data_r;

endmodule

// ===== rtl/atu_gain_stage.sv =====
module atu_gain_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_vld,
  output logic           up_rdy,
  input  atu_pkg::cord_t up_data,
  output logic           dn_vld,
  input  logic           dn_rdy,
  output atu_pkg::cord_t dn_data
);

  localparam int PW = atu_pkg::MAG_W + atu_pkg::GAIN_W;

  logic                           vld_r;
  atu_pkg::cord_t                 data_r;
  atu_pkg::cord_t                 data_nxt;
  logic [PW-1:0]                  prod;
  logic [atu_pkg::MAG_W-1:0]      mag_c;

  assign up_rdy = !vld_r || dn_rdy;

  // magnitude * 1/K, Q30; the magnitude is never negative so the shift is logical
  always_comb begin
    prod  = PW'(up_data.a[atu_pkg::MAG_W-1:0]) * PW'(atu_pkg::INV_GAIN_Q30);
    mag_c = prod[atu_pkg::GAIN_SH +: atu_pkg::MAG_W];
    data_nxt       = up_data;
    data_nxt.a     = {{(atu_pkg::DW - atu_pkg::MAG_W){1'b0}}, mag_c};
    data_nxt.b     = up_data.y_raw;
    data_nxt.z     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      data_r <= data_nxt;
    end
  end

  assign dn_vld  = vld_r;
  assign dn_data = data_r;

endmodule

// ===== rtl/accel_tilt_angle_unit.sv =====
// Tilt about the X axis, atan2(Y, sqrt(X^2 + Z^2)), from one raw signed 16-bit
// accelerometer sample, returned in units of 2^-ANGLE_FRAC_BITS degree and
// clamped to +-90 degrees; a sample with Y == 0 gives exactly 0. The block is a
// chain of CORDIC cells: CORDIC_STEPS magnitude cells (capped at TABLE_LEN = 24)
// on (|X|, |Z|), one gain multiply stage, as many angle cells on (magnitude, Y),
// and an output register that rounds and saturates. One sample is taken every
// cycle while in_stall is low. Each cell holds its own valid bit, so bubbles
// close up while the output is stalled and in_stall rises only once every stage
// is full.
module accel_tilt_angle_unit #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [atu_pkg::IN_W-1:0]   in_acc_x,
  input  logic signed [atu_pkg::IN_W-1:0]   in_acc_y,
  input  logic signed [atu_pkg::IN_W-1:0]   in_acc_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [atu_pkg::OUT_W-1:0]  out_tilt_deg
);

  localparam int NSTEPS = (CORDIC_STEPS > atu_pkg::TABLE_LEN) ? atu_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;
  localparam int SH = atu_pkg::ANG_Q - ANGLE_FRAC_BITS;
  localparam logic signed [atu_pkg::ZW-1:0] RND = atu_pkg::ZW'(1) <<< (SH - 1);
  localparam logic signed [atu_pkg::ZW-1:0] LIM =
    atu_pkg::ZW'(atu_pkg::ANG_LIMIT_DEG) <<< ANGLE_FRAC_BITS;

  logic            mag_vld  [NSTEPS+1];
  logic            mag_rdy  [NSTEPS+1];
  atu_pkg::cord_t  mag_data [NSTEPS+1];
  logic            ang_vld  [NSTEPS+1];
  logic            ang_rdy  [NSTEPS+1];
  atu_pkg::cord_t  ang_data [NSTEPS+1];

  logic signed [atu_pkg::DW-1:0]    x_ext;
  logic signed [atu_pkg::DW-1:0]    y_ext;
  logic signed [atu_pkg::DW-1:0]    z_ext;
  logic                             out_rdy;
  logic                             out_valid_r;
  logic signed [atu_pkg::OUT_W-1:0] out_tilt_r;
  logic signed [atu_pkg::OUT_W-1:0] out_tilt_nxt;
  logic signed [atu_pkg::ZW-1:0]    rsum;
  logic signed [atu_pkg::ZW-1:0]    res;

  // input transaction feeds the first magnitude cell directly
  always_comb begin
    x_ext = atu_pkg::DW'(in_acc_x);
    y_ext = atu_pkg::DW'(in_acc_y);
    z_ext = atu_pkg::DW'(in_acc_z);
    if (x_ext < 0) x_ext = -x_ext;
    if (z_ext < 0) z_ext = -z_ext;
    mag_data[0].a     = x_ext <<< atu_pkg::IN_SHIFT;
    mag_data[0].b     = z_ext <<< atu_pkg::IN_SHIFT;
    mag_data[0].z     = '0;
    mag_data[0].y_raw = y_ext <<< atu_pkg::IN_SHIFT;
    mag_data[0].zero  = (in_acc_y == '0);
  end

  assign mag_vld[0] = in_valid;
  assign in_stall   = !mag_rdy[0];

  for (genvar i = 0; i < NSTEPS; i++) begin : g_mag
    atu_cordic_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .angle_mode (1'b0),
      .step       (atu_pkg::STEP_W'(i)),
      .atan_val   (atu_pkg::atan_q20(i)),
      .up_vld     (mag_vld[i]),
      .up_rdy     (mag_rdy[i]),
      .up_data    (mag_data[i]),
      .dn_vld     (mag_vld[i+1]),
      .dn_rdy     (mag_rdy[i+1]),
      .dn_data    (mag_data[i+1])
    );
  end

  atu_gain_stage u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (mag_vld[NSTEPS]),
    .up_rdy  (mag_rdy[NSTEPS]),
    .up_data (mag_data[NSTEPS]),
    .dn_vld  (ang_vld[0]),
    .dn_rdy  (ang_rdy[0]),
    .dn_data (ang_data[0])
  );

  for (genvar i = 0; i < NSTEPS; i++) begin : g_ang
    atu_cordic_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .angle_mode (1'b1),
      .step       (atu_pkg::STEP_W'(i)),
      .atan_val   (atu_pkg::atan_q20(i)),
      .up_vld     (ang_vld[i]),
      .up_rdy     (ang_rdy[i]),
      .up_data    (ang_data[i]),
      .dn_vld     (ang_vld[i+1]),
      .dn_rdy     (ang_rdy[i+1]),
      .dn_data    (ang_data[i+1])
    );
  end

  // round half up to the output fraction, clamp to +-90 degrees
  always_comb begin
    rsum = ang_data[NSTEPS].z + RND;
    res  = rsum >>> SH;
    if (res > LIM)  res = LIM;
    if (res < -LIM) res = -LIM;
    out_tilt_nxt = ang_data[NSTEPS].zero ? '0 : res[atu_pkg::OUT_W-1:0];
  end

  assign out_rdy         = !out_valid_r || !out_stall;
  assign ang_rdy[NSTEPS] = out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= ang_vld[NSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && ang_vld[NSTEPS]) begin
      out_tilt_r <= out_tilt_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_tilt_deg = out_tilt_r;

  // the chain backs up only behind a stalled output
  a_stall_needs_out_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("input stalled while output is free");

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_refill_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && ang_vld[NSTEPS]) |=> out_valid)
    else $error("pending result lost at output register");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int PIPE_LATENCY    = 2 * CORDIC_STEPS + 2;
  localparam int RANDOM_SAMPLES  = 1600;
  localparam int STALL_LIMIT     = 4000;

  // atan(2^-i) in Q20 degrees
  localparam longint ATAN_DEG_Q20 [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct {
    logic signed [atu_pkg::IN_W-1:0] x;
    logic signed [atu_pkg::IN_W-1:0] y;
    logic signed [atu_pkg::IN_W-1:0] z;
  } accel_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [atu_pkg::IN_W-1:0] in_acc_x = '0;
  logic signed [atu_pkg::IN_W-1:0] in_acc_y = '0;
  logic signed [atu_pkg::IN_W-1:0] in_acc_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [atu_pkg::OUT_W-1:0] out_tilt_deg;

  accel_sample_t pending_samples[$];
  logic signed [atu_pkg::OUT_W-1:0] tilt_expect_q[$];
  int total_samples = 0;
  int accepted_cnt = 0;
  int err_cnt = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;

  accel_tilt_angle_unit #(
    .CORDIC_STEPS    (CORDIC_STEPS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_acc_x     (in_acc_x),
    .in_acc_y     (in_acc_y),
    .in_acc_z     (in_acc_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_tilt_deg (out_tilt_deg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Two vectoring passes: |(|X|,|Z|)| with gain compensation, then angle of (mag, Y).
  function automatic logic signed [atu_pkg::OUT_W-1:0] predict_tilt(
      logic signed [atu_pkg::IN_W-1:0] ax,
      logic signed [atu_pkg::IN_W-1:0] ay,
      logic signed [atu_pkg::IN_W-1:0] az);
    longint a, b, xs, ys, mag, ang, res, lim;
    int n, sh;
    n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    sh = atu_pkg::ANG_Q - ANGLE_FRAC_BITS;
    lim = longint'(atu_pkg::ANG_LIMIT_DEG) <<< ANGLE_FRAC_BITS;
    if (ay == 0) return '0;
    a = (ax < 0) ? -longint'(ax) : longint'(ax);
    b = (az < 0) ? -longint'(az) : longint'(az);
    a = a <<< atu_pkg::IN_SHIFT;
    b = b <<< atu_pkg::IN_SHIFT;
    for (int i = 0; i < n; i++) begin
      xs = a >>> i;
      ys = b >>> i;
      if (b >= 0) begin
        a += ys;
        b -= xs;
      end else begin
        a -= ys;
        b += xs;
      end
    end
    mag = (a * 64'sd652032874) >>> atu_pkg::GAIN_SH;
    a = mag;
    b = longint'(ay) <<< atu_pkg::IN_SHIFT;
    ang = 0;
    for (int i = 0; i < n; i++) begin
      xs = a >>> i;
      ys = b >>> i;
      if (b > 0) begin
        a += ys;
        b -= xs;
        ang += ATAN_DEG_Q20[i];
      end else begin
        a -= ys;
        b += xs;
        ang -= ATAN_DEG_Q20[i];
      end
    end
    res = (ang + (longint'(1) <<< (sh - 1))) >>> sh;
    if (res > lim) res = lim;
    if (res < -lim) res = -lim;
    return res[atu_pkg::OUT_W-1:0];
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [atu_pkg::IN_W-1:0] rand_axis(int mode);
    logic signed [atu_pkg::IN_W-1:0] corner [6];
    corner = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case (mode)
      0: return atu_pkg::IN_W'($urandom());
      1: return atu_pkg::IN_W'(int'($urandom_range(0, 600)) - 300);
      2: return corner[$urandom_range(0, 5)];
      default: return atu_pkg::IN_W'(int'($urandom_range(0, 20)) - 10);
    endcase
  endfunction

  task automatic add_sample(int x, int y, int z);
    accel_sample_t s;
    s.x = atu_pkg::IN_W'(x);
    s.y = atu_pkg::IN_W'(y);
    s.z = atu_pkg::IN_W'(z);
    pending_samples.push_back(s);
    total_samples++;
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) quiet_phase <= !quiet_phase;
  end

  // input driver
  always @(posedge clk) begin
    accel_sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tilt_expect_q.push_back(predict_tilt(in_acc_x, in_acc_y, in_acc_z));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s = pending_samples.pop_front();
          in_acc_x <= s.x;
          in_acc_y <= s.y;
          in_acc_z <= s.z;
          in_valid <= 1'b1;
          gap_cnt <= idle_len(quiet_phase);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output backpressure
  always @(posedge clk) begin
    logic signed [atu_pkg::OUT_W-1:0] exp_tilt;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tilt_expect_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual tilt_deg %0d",
                   $time, out_tilt_deg);
          err_cnt++;
        end else begin
          exp_tilt = tilt_expect_q.pop_front();
          if (out_tilt_deg !== exp_tilt) begin
            $display("%0t: tilt_deg mismatch, expected %0d, actual %0d",
                     $time, exp_tilt, out_tilt_deg);
            err_cnt++;
          end
        end
      end
      out_stall <= (stall_cnt != 0);
      stall_cnt <= (stall_cnt != 0) ? stall_cnt - 1 : idle_len(quiet_phase);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int mode, pick;
    // directed: zero Y, vertical Y, extremes, diagonals
    add_sample(0, 0, 0);
    add_sample(100, 0, -200);
    add_sample(-32768, 0, 32767);
    add_sample(0, 1, 0);
    add_sample(0, -1, 0);
    add_sample(0, 32767, 0);
    add_sample(0, -32768, 0);
    add_sample(-32768, -32768, -32768);
    add_sample(32767, 32767, 32767);
    add_sample(-32768, 32767, -32768);
    add_sample(32767, -32768, 32767);
    add_sample(1, 1, 1);
    add_sample(-1, -1, -1);
    add_sample(32767, 1, 0);
    add_sample(0, -1, -32768);
    add_sample(1000, 1000, 0);
    add_sample(0, 1000, -1000);
    add_sample(-16384, 12345, -16384);
    add_sample(-32768, 32767, 0);
    add_sample(0, -32768, 1);
    for (int k = 0; k < RANDOM_SAMPLES; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) mode = 0;
      else if (pick < 70) mode = 1;
      else if (pick < 80) mode = 2;
      else mode = 3;
      if (pick >= 90 && pick < 95) begin
        // X and Z both zero: angle runs toward +-90
        add_sample(0, int'(rand_axis(0)), 0);
      end else if (pick >= 95) begin
        add_sample(int'(rand_axis(0)), 0, int'(rand_axis(0)));
      end else begin
        add_sample(int'(rand_axis(mode)), int'(rand_axis($urandom_range(0, 3))),
                   int'(rand_axis(mode)));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_samples || tilt_expect_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
